// ===== rtl/pose_residual_transform_core_macros.svh =====
// ----------------------------------------------------------------------------
// pose_residual_transform_core_macros
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef POSE_RESIDUAL_TRANSFORM_CORE_MACROS_SVH
`define POSE_RESIDUAL_TRANSFORM_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg
// Types and constants shared by the pose residual transform blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

  localparam int PRT_FRAC_BITS = 16;
  localparam int QBITS         = 30;
  localparam int PW            = 32;
  localparam int MAT_W         = 33;
  localparam int CNT_W         = 5;

  localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(2);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QBITS + 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(8);

  typedef enum logic [2:0] {
    REG_ROT_A,
    REG_ROT_B,
    REG_ROT_C,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHIFT_Z
  } prt_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_MAT
  } prt_state_t;

  typedef struct packed {
    logic signed [PW-1:0] moved_x;
    logic signed [PW-1:0] moved_y;
    logic signed [PW-1:0] moved_z;
    logic signed [PW-1:0] ref_x;
    logic signed [PW-1:0] ref_y;
    logic signed [PW-1:0] ref_z;
    logic                 last_point;
  } prt_in_t;

  typedef struct packed {
    logic signed [PW-1:0] err_x;
    logic signed [PW-1:0] err_y;
    logic signed [PW-1:0] err_z;
    logic                 last_residual;
  } prt_out_t;

  typedef struct packed {
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    logic signed [PW-1:0] c;
  } prt_rot_par_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
  } prt_shift_t;

  typedef struct packed {
    logic busy;
    logic mat_write;
  } prt_bld_stat_t;

  typedef logic [MAT_W-1:0] prt_entry_t;
  typedef prt_entry_t [8:0] prt_mat_t;

endpackage

`default_nettype wire

// ===== rtl/prt_rot_builder.sv =====
// ----------------------------------------------------------------------------
// prt_rot_builder
// Sequencer that turns the rotation parameters into a Q30 rotation matrix
// with a squarer, one shared product multiplier and a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pose_residual_transform_core_macros.svh"

module prt_rot_builder #(
  parameter int FRAC_BITS = prt_pkg::PRT_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  restart,
  input  wire prt_pkg::prt_rot_par_t rot_param,
  output prt_pkg::prt_mat_t          mat,
  output prt_pkg::prt_bld_stat_t     stat
);
  import prt_pkg::*;

  localparam logic [63:0] ONE2 = 64'(1) << (2 * FRAC_BITS);
  localparam logic signed [63:0] ONE60 = 64'sd1 <<< (2 * QBITS);
  localparam logic [64:0] RND = 65'(1) << (QBITS - 1);
  localparam logic [MAT_W-1:0] UNIT = MAT_W'(1) << QBITS;

  localparam int PXX = 0;
  localparam int PYY = 1;
  localparam int PZZ = 2;
  localparam int PXY = 3;
  localparam int PXZ = 4;
  localparam int PYZ = 5;
  localparam int PXW = 6;
  localparam int PYW = 7;
  localparam int PZW = 8;

  function automatic logic [PW-1:0] mag32(input logic signed [PW-1:0] v);
    return v[PW-1] ? (~v + PW'(1)) : v;
  endfunction

  function automatic logic [MAT_W-1:0] round_q(input logic signed [63:0] v);
    logic [63:0] m;
    logic [64:0] r;
    logic [MAT_W-1:0] rm;
    m  = v[63] ? 64'(-v) : 64'(v);
    r  = 65'(m) + RND;
    rm = r[QBITS+MAT_W-1:QBITS];
    return v[63] ? (~rm + MAT_W'(1)) : rm;
  endfunction

  prt_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] op_r, op_nxt;

  logic sq_en, prep_en, div_en, mul_en, mat_en;

  logic [63:0] s_r, den_r, num_r, rem_r;
  logic        negw_r;
  logic [31:0] quo_r;
  logic signed [31:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [63:0] prod_r [9];
  prt_mat_t mat_r;

  // Sequencer: next state and counters.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CNT_W'(1);
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
      end
      ST_SQ: begin
        if (cnt_r == SQ_LAST) begin
          state_nxt = ST_PREP;
          cnt_nxt   = '0;
        end
      end
      ST_PREP: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
        op_nxt    = '0;
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          op_nxt  = op_r + 2'd1;
          if (op_r == 2'd3) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_MAT;
          cnt_nxt   = '0;
        end
      end
      ST_MAT: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
    if (restart) begin
      state_nxt = ST_SQ;
      cnt_nxt   = '0;
    end
  end

  // Sequencer: outputs.
  always_comb begin
    sq_en   = 1'b0;
    prep_en = 1'b0;
    div_en  = 1'b0;
    mul_en  = 1'b0;
    mat_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_SQ:   sq_en   = 1'b1;
      ST_PREP: prep_en = 1'b1;
      ST_DIV:  div_en  = 1'b1;
      ST_MUL:  mul_en  = 1'b1;
      ST_MAT:  mat_en  = 1'b1;
      default: ;
    endcase
    stat.busy      = (state_r != ST_IDLE);
    stat.mat_write = mat_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
  end

  // Sum of squares, one parameter per cycle.
  logic [PW-1:0] sq_mag;
  logic [63:0]   sq_prod;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    sq_mag = mag32(rot_param.a);
      2'd1:    sq_mag = mag32(rot_param.b);
      default: sq_mag = mag32(rot_param.c);
    endcase
    sq_prod = 64'(sq_mag) * 64'(sq_mag);
  end

  // Restoring divider step. The first step of each quotient takes no shift.
  logic [63:0] div_op, rem_nxt;
  logic [64:0] rem_sh;
  logic        div_bit;
  logic [31:0] quo_nxt;
  logic [32:0] quo_rnd;
  logic [31:0] q_mag, q_val;
  logic        q_neg;

  always_comb begin
    unique case (op_r)
      2'd0:    div_op = num_r;
      2'd1:    div_op = 64'(mag32(rot_param.a)) << (FRAC_BITS + 1);
      2'd2:    div_op = 64'(mag32(rot_param.b)) << (FRAC_BITS + 1);
      default: div_op = 64'(mag32(rot_param.c)) << (FRAC_BITS + 1);
    endcase
    unique case (op_r)
      2'd0:    q_neg = negw_r;
      2'd1:    q_neg = rot_param.a[PW-1];
      2'd2:    q_neg = rot_param.b[PW-1];
      default: q_neg = rot_param.c[PW-1];
    endcase
    if (cnt_r == '0) begin
      rem_sh = {1'b0, div_op};
    end else begin
      rem_sh = {rem_r, 1'b0};
    end
    div_bit = (rem_sh >= {1'b0, den_r});
    rem_nxt = div_bit ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
    quo_nxt = {quo_r[30:0], div_bit};
    quo_rnd = 33'(quo_nxt) + 33'd1;
    q_mag   = quo_rnd[32:1];
    q_val   = q_neg ? (~q_mag + 32'd1) : q_mag;
  end

  // Quaternion products, one per cycle.
  logic signed [31:0] ma, mb;
  logic signed [63:0] mprod;

  always_comb begin
    unique case (cnt_r[3:0])
      4'd0:    begin ma = qx_r; mb = qx_r; end
      4'd1:    begin ma = qy_r; mb = qy_r; end
      4'd2:    begin ma = qz_r; mb = qz_r; end
      4'd3:    begin ma = qx_r; mb = qy_r; end
      4'd4:    begin ma = qx_r; mb = qz_r; end
      4'd5:    begin ma = qy_r; mb = qz_r; end
      4'd6:    begin ma = qx_r; mb = qw_r; end
      4'd7:    begin ma = qy_r; mb = qw_r; end
      default: begin ma = qz_r; mb = qw_r; end
    endcase
    mprod = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (sq_en) begin
      s_r <= (cnt_r == '0) ? sq_prod : s_r + sq_prod;
    end
    if (prep_en) begin
      den_r  <= ONE2 + s_r;
      num_r  <= (s_r <= ONE2) ? (ONE2 - s_r) : (s_r - ONE2);
      negw_r <= (s_r > ONE2);
    end
    if (div_en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cnt_r == DIV_LAST) begin
        unique case (op_r)
          2'd0:    qw_r <= q_val;
          2'd1:    qx_r <= q_val;
          2'd2:    qy_r <= q_val;
          default: qz_r <= q_val;
        endcase
      end
    end
    if (mul_en && (cnt_r <= MUL_LAST)) begin
      prod_r[cnt_r[3:0]] <= mprod;
    end
  end

  // The matrix resets to the identity, which is what zero parameters give.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        mat_r[k] <= ((k % 4) == 0) ? UNIT : '0;
      end
    end else if (mat_en) begin
      mat_r[0] <= round_q(ONE60 - ((prod_r[PYY] + prod_r[PZZ]) <<< 1));
      mat_r[1] <= round_q((prod_r[PXY] - prod_r[PZW]) <<< 1);
      mat_r[2] <= round_q((prod_r[PXZ] + prod_r[PYW]) <<< 1);
      mat_r[3] <= round_q((prod_r[PXY] + prod_r[PZW]) <<< 1);
      mat_r[4] <= round_q(ONE60 - ((prod_r[PXX] + prod_r[PZZ]) <<< 1));
      mat_r[5] <= round_q((prod_r[PYZ] - prod_r[PXW]) <<< 1);
      mat_r[6] <= round_q((prod_r[PXZ] - prod_r[PYW]) <<< 1);
      mat_r[7] <= round_q((prod_r[PYZ] + prod_r[PXW]) <<< 1);
      mat_r[8] <= round_q(ONE60 - ((prod_r[PXX] + prod_r[PYY]) <<< 1));
    end
  end

  assign mat = mat_r;

  `PRT_ASSERT_NEXT(a_mat_only_on_write, !mat_en, $stable(mat_r), "matrix changed outside its write step")

endmodule

`default_nettype wire

// ===== rtl/prt_point_pipe.sv =====
// ----------------------------------------------------------------------------
// prt_point_pipe
// Three-stage point path: input register, row products, residual result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pose_residual_transform_core_macros.svh"

module prt_point_pipe (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                hold,
  input  wire prt_pkg::prt_mat_t   mat,
  input  wire prt_pkg::prt_shift_t shift,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire prt_pkg::prt_in_t    in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output prt_pkg::prt_out_t        out_data
);
  import prt_pkg::*;

  localparam logic [67:0] RND = 68'(1) << (QBITS - 1);
  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  logic    s0_v_r, s1_v_r, out_v_r;
  logic    s0_en, s1_en, out_en;
  prt_in_t s0_r;
  logic signed [64:0] prod_r [9];
  logic signed [32:0] d_r [3];
  logic    s1_last_r;
  prt_out_t out_r;

  // Each stage moves on when the one after it is empty or moving.
  assign out_en   = !out_v_r || !out_stall;
  assign s1_en    = !s1_v_r || out_en;
  assign s0_en    = !s0_v_r || s1_en;
  assign in_stall = hold || !s0_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s0_en) s0_v_r <= in_valid && !in_stall;
      if (s1_en) s1_v_r <= s0_v_r;
      if (out_en) out_v_r <= s1_v_r;
    end
  end

  logic signed [PW-1:0] mv [3];
  logic signed [PW-1:0] rf [3];
  logic signed [PW-1:0] tv [3];

  always_comb begin
    mv[0] = s0_r.moved_x;
    mv[1] = s0_r.moved_y;
    mv[2] = s0_r.moved_z;
    rf[0] = s0_r.ref_x;
    rf[1] = s0_r.ref_y;
    rf[2] = s0_r.ref_z;
    tv[0] = shift.x;
    tv[1] = shift.y;
    tv[2] = shift.z;
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_r <= in_data;
    end
    if (s1_en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i*3+j] <= $signed(mat[i*3+j]) * mv[j];
        end
        d_r[i] <= 33'(tv[i]) - 33'(rf[i]);
      end
      s1_last_r <= s0_r.last_point;
    end
  end

  // Row sum, rounding of the magnitude to Q(FRAC_BITS), offset and clamp.
  logic signed [66:0] acc [3];
  logic [66:0]        acc_mag [3];
  logic [67:0]        rnd [3];
  logic signed [38:0] rs [3];
  logic signed [39:0] tot [3];
  logic [PW-1:0]      res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 67'(prod_r[i*3]) + 67'(prod_r[i*3+1]) + 67'(prod_r[i*3+2]);
      acc_mag[i] = acc[i][66] ? 67'(-acc[i]) : 67'(acc[i]);
      rnd[i] = 68'(acc_mag[i]) + RND;
      rs[i] = acc[i][66] ? -$signed({1'b0, rnd[i][67:QBITS]})
                         : $signed({1'b0, rnd[i][67:QBITS]});
      tot[i] = 40'(rs[i]) + 40'(d_r[i]);
      if (tot[i] > SAT_HI) begin
        res[i] = 32'h7fff_ffff;
      end else if (tot[i] < SAT_LO) begin
        res[i] = 32'h8000_0000;
      end else begin
        res[i] = tot[i][PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_r.err_x         <= res[0];
      out_r.err_y         <= res[1];
      out_r.err_z         <= res[2];
      out_r.last_residual <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `PRT_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, s0_v_r, "accepted request not captured")
  `PRT_ASSERT_NEXT(a_no_drop, s1_v_r && out_v_r && out_stall, s1_v_r, "stage one item lost under stall")

endmodule

`default_nettype wire

// ===== rtl/pose_residual_transform_core.sv =====
// ----------------------------------------------------------------------------
// pose_residual_transform_core
// Rigid-transform point residual: err = R * moved + t - ref, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
// The configuration port writes the pose: indices 0 to 2 hold the rotation
// parameters, 3 to 5 the translation. A write to a rotation parameter starts
// a rebuild of the rotation matrix (three squarings, a preparation step, four
// 32-step divisions, nine products and the final rounding); in_stall is held
// high during the rebuild and in the cycle of any write.
// Each request on the input channel carries one point pair; each gives one
// result request on the output channel, in order, after the input register,
// the row products and the result register. One point is taken per cycle
// while the output side keeps up and no write or rebuild holds the input; a
// stalled output holds its result and the pipeline keeps filling until all
// three stages are full. Reset clears the pose to zero, so the matrix is the
// identity, and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_residual_transform_core #(
  parameter int FRAC_BITS = prt_pkg::PRT_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire prt_pkg::prt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output prt_pkg::prt_out_t     out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_wdata
);
  import prt_pkg::*;

  prt_rot_par_t  rot_r;
  prt_shift_t    shift_r;
  prt_mat_t      mat;
  prt_bld_stat_t stat;
  logic          restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r   <= '0;
      shift_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (prt_reg_t'(cfg_index))
        REG_ROT_A:   rot_r.a   <= cfg_wdata;
        REG_ROT_B:   rot_r.b   <= cfg_wdata;
        REG_ROT_C:   rot_r.c   <= cfg_wdata;
        REG_SHIFT_X: shift_r.x <= cfg_wdata;
        REG_SHIFT_Y: shift_r.y <= cfg_wdata;
        REG_SHIFT_Z: shift_r.z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Only the rotation parameters feed the matrix.
  assign restart = cfg_wr_en && ((cfg_index == REG_ROT_A) || (cfg_index == REG_ROT_B) ||
                                 (cfg_index == REG_ROT_C));

  prt_rot_builder #(
    .FRAC_BITS(FRAC_BITS)
  ) u_builder (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .rot_param(rot_r),
    .mat      (mat),
    .stat     (stat)
  );

  prt_point_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold     (cfg_wr_en || stat.busy || stat.mat_write),
    .mat      (mat),
    .shift    (shift_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Pose residual transform core testbench
// Loads a series of poses through the configuration port and pushes point
// pairs through the core. Each residual is checked against a local
// fixed-point predictor of the rotation build and the residual datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import prt_pkg::*;

  localparam int FB = PRT_FRAC_BITS;
  localparam int QB = 30;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  prt_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  prt_out_t   out_data;
  logic       cfg_wr_en;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  pose_residual_transform_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Local copy of the pose and the rotation matrix derived from it.
  longint   pose_reg [6];
  longint   rot_mat [9];
  prt_out_t residual_q [$];
  int       fail_cnt;
  int       checked_cnt;
  int       sent_cnt;
  int       pose_cnt;
  bit       calm;
  int       hold_len;
  int       stall_left;
  bit       stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[pose_residual_transform_core] ERROR");
    $finish;
  end

  function automatic bit [63:0] ratio_q30(bit [63:0] num, bit [63:0] den);
    bit [63:0] q;
    bit [63:0] rem;
    bit        top;
    q = 0;
    rem = num;
    if (rem >= den) begin
      rem = rem - den;
      q = 1;
    end
    for (int i = 0; i < QB + 1; i++) begin
      top = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (top || rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic longint round_off(longint v, int sh);
    bit [63:0] m;
    bit [63:0] r;
    m = (v < 0) ? -v : v;
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Rebuilds the rotation matrix from the rotation parameters.
  function automatic void rebuild_rotation();
    bit [63:0] one2;
    bit [63:0] s;
    bit [63:0] den;
    bit [63:0] num;
    bit [63:0] m;
    longint    one60;
    longint    q [3];
    longint    w;
    longint    xx, yy, zz, xy, xz, yz, xw, yw, zw;
    one2 = 64'd1 << (2 * FB);
    one60 = longint'(1) << (2 * QB);
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = (pose_reg[i] < 0) ? -pose_reg[i] : pose_reg[i];
      s = s + m * m;
    end
    den = one2 + s;
    num = (s <= one2) ? one2 - s : s - one2;
    w = longint'(ratio_q30(num, den));
    if (s > one2) w = -w;
    for (int i = 0; i < 3; i++) begin
      m = (pose_reg[i] < 0) ? -pose_reg[i] : pose_reg[i];
      q[i] = longint'(ratio_q30(m << (FB + 1), den));
      if (pose_reg[i] < 0) q[i] = -q[i];
    end
    xx = q[0] * q[0]; yy = q[1] * q[1]; zz = q[2] * q[2];
    xy = q[0] * q[1]; xz = q[0] * q[2]; yz = q[1] * q[2];
    xw = q[0] * w;    yw = q[1] * w;    zw = q[2] * w;
    rot_mat[0] = round_off(one60 - 2 * (yy + zz), QB);
    rot_mat[1] = round_off(2 * (xy - zw), QB);
    rot_mat[2] = round_off(2 * (xz + yw), QB);
    rot_mat[3] = round_off(2 * (xy + zw), QB);
    rot_mat[4] = round_off(one60 - 2 * (xx + zz), QB);
    rot_mat[5] = round_off(2 * (yz - xw), QB);
    rot_mat[6] = round_off(2 * (xz - yw), QB);
    rot_mat[7] = round_off(2 * (yz + xw), QB);
    rot_mat[8] = round_off(one60 - 2 * (xx + yy), QB);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic prt_out_t predict_residual(prt_in_t d);
    prt_out_t res;
    longint   mv [3];
    longint   rf [3];
    longint   acc;
    mv[0] = longint'(d.moved_x); mv[1] = longint'(d.moved_y); mv[2] = longint'(d.moved_z);
    rf[0] = longint'(d.ref_x);   rf[1] = longint'(d.ref_y);   rf[2] = longint'(d.ref_z);
    acc = rot_mat[0] * mv[0] + rot_mat[1] * mv[1] + rot_mat[2] * mv[2];
    res.err_x = clamp32(round_off(acc, QB) + pose_reg[3] - rf[0]);
    acc = rot_mat[3] * mv[0] + rot_mat[4] * mv[1] + rot_mat[5] * mv[2];
    res.err_y = clamp32(round_off(acc, QB) + pose_reg[4] - rf[1]);
    acc = rot_mat[6] * mv[0] + rot_mat[7] * mv[1] + rot_mat[8] * mv[2];
    res.err_z = clamp32(round_off(acc, QB) + pose_reg[5] - rf[2]);
    res.last_residual = d.last_point;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      4: return 32'h0;
      default: return 32'($urandom_range(0, 32'h00ffffff)) - 32'h00800000;
    endcase
  endfunction

  function automatic prt_in_t pick_point();
    prt_in_t d;
    d.moved_x = pick_word(); d.moved_y = pick_word(); d.moved_z = pick_word();
    d.ref_x = pick_word();   d.ref_y = pick_word();   d.ref_z = pick_word();
    d.last_point = ($urandom_range(0, 7) == 0);
    return d;
  endfunction

  // Offers one request and returns once it has been taken and any idle gap has passed.
  task automatic send_point(prt_in_t d);
    int gap;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    residual_q.push_back(predict_residual(d));
    sent_cnt++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (residual_q.size() == 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx <= REG_SHIFT_Z) begin
      pose_reg[idx] = longint'(signed'(val));
      rebuild_rotation();
    end
    repeat (3) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_pose(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    drain();
    write_reg(REG_ROT_A, a);
    write_reg(REG_ROT_B, b);
    write_reg(REG_ROT_C, c);
    write_reg(REG_SHIFT_X, tx);
    write_reg(REG_SHIFT_Y, ty);
    write_reg(REG_SHIFT_Z, tz);
    pose_cnt++;
  endtask

  task automatic test_identity_edges();
    prt_in_t d;
    logic [31:0] edge_val [4];
    edge_val[0] = 32'h7fffffff; edge_val[1] = 32'h80000000;
    edge_val[2] = 32'h0;        edge_val[3] = 32'hffffffff;
    calm = 1'b1;
    for (int i = 0; i < 16; i++) begin
      d.moved_x = edge_val[i % 4];        d.moved_y = edge_val[(i + 1) % 4];
      d.moved_z = edge_val[(i + 2) % 4];  d.ref_x = edge_val[(i / 4) % 4];
      d.ref_y = edge_val[(i + 3) % 4];    d.ref_z = edge_val[(i / 4 + 1) % 4];
      d.last_point = i[0];
      send_point(d);
    end
    calm = 1'b0;
    drain();
  endtask

  task automatic test_unknown_index();
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    for (int i = 0; i < 8; i++) send_point(pick_point());
    drain();
  endtask

  task automatic test_pose_sweep();
    logic [31:0] p [6];
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 6; i++) p[i] = pick_word();
      case (k)
        0: begin p[0] = 32'h00010000; p[1] = 0; p[2] = 0; end
        1: begin p[0] = 32'h00002000; p[1] = 32'hffffe800; p[2] = 32'h00000400; end
        2: begin
          p[0] = 32'h7fffffff; p[1] = 32'h7fffffff; p[2] = 32'h7fffffff;
          p[3] = 32'h7fffffff; p[4] = 32'h7fffffff; p[5] = 32'h7fffffff;
        end
        3: begin
          p[0] = 32'h80000000; p[1] = 32'h80000000; p[2] = 32'h80000000;
          p[3] = 32'h80000000; p[4] = 32'h80000000; p[5] = 32'h80000000;
        end
        4: begin p[0] = 32'h00009000; p[1] = 32'h00007000; p[2] = 32'hffff0000; end
        default: ;
      endcase
      load_pose(p[0], p[1], p[2], p[3], p[4], p[5]);
      calm = (k == 5);
      for (int n = 0; n < 150; n++) send_point(pick_point());
      calm = 1'b0;
    end
    drain();
  endtask

  task automatic test_output_holdoff();
    hold_len = 200;
    for (int n = 0; n < 60; n++) send_point(pick_point());
    drain();
  endtask

  task automatic test_sender_pause();
    for (int n = 0; n < 20; n++) send_point(pick_point());
    in_valid <= 1'b0;
    wait (residual_q.size() == 0);
    @(posedge clk);
    for (int n = 0; n < 20; n++) send_point(pick_point());
    drain();
  endtask

  // Output back-pressure: runs of stall or flow, plus an occasional long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_on = ($urandom_range(0, 2) == 0);
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 4);
      end
      stall_left = stall_left - 1;
      out_stall <= stall_on;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (residual_q.size() == 0) begin
        $error("residual request with no point outstanding");
        fail_cnt++;
      end else begin
        prt_out_t want;
        want = residual_q.pop_front();
        checked_cnt++;
        if (out_data.err_x !== want.err_x) begin
          $error("err_x expected %0d got %0d", want.err_x, out_data.err_x);
          fail_cnt++;
        end
        if (out_data.err_y !== want.err_y) begin
          $error("err_y expected %0d got %0d", want.err_y, out_data.err_y);
          fail_cnt++;
        end
        if (out_data.err_z !== want.err_z) begin
          $error("err_z expected %0d got %0d", want.err_z, out_data.err_z);
          fail_cnt++;
        end
        if (out_data.last_residual !== want.last_residual) begin
          $error("last_residual expected %0b got %0b",
                 want.last_residual, out_data.last_residual);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    fail_cnt = 0; checked_cnt = 0; sent_cnt = 0; pose_cnt = 0;
    calm = 1'b0; hold_len = 0; stall_left = 0; stall_on = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < 6; i++) pose_reg[i] = 0;
    rebuild_rotation();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    test_identity_edges();
    test_unknown_index();
    test_pose_sweep();
    test_output_holdoff();
    test_sender_pause();
    load_pose(0, 0, 0, 0, 0, 0);
    test_identity_edges();

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d point pairs over %0d poses, %0d residuals checked.",
             sent_cnt, pose_cnt, checked_cnt);
    if (fail_cnt == 0) begin
      $display("[pose_residual_transform_core] OK");
    end else begin
      $display("[pose_residual_transform_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/prt_pkg.sv
rtl/prt_rot_builder.sv
rtl/prt_point_pipe.sv
rtl/pose_residual_transform_core.sv
verif/testbench.sv
